>>> design/adam_pkg.sv
`timescale 1ns / 1ps

package adam_pkg;

	// Field and word widths
	localparam int WORD_W      = 32;
	localparam int IDX_W       = 12;
	localparam int PARAM_COUNT = 4096;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_IDX_W   = 2;

	// Opcodes carried in tuser
	localparam logic OP_ELEM = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B1  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B2  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EPS = 2'd3;

	// Register reset values
	localparam logic [WORD_W-1:0] LR_RST  = 32'd4294967;
	localparam logic [WORD_W-1:0] B1_RST  = 32'd3865470566;
	localparam logic [WORD_W-1:0] B2_RST  = 32'd4290672329;
	localparam logic [WORD_W-1:0] EPS_RST = 32'd43;

	// 1.0 in Q0.32, one bit wider than a word
	localparam logic [WORD_W:0] ONE_Q = {1'b1, {WORD_W{1'b0}}};

	// Root and divide datapaths
	localparam int SQ_REM_W   = 36;
	localparam int DV_REM_W   = 42;
	localparam int Q_W        = 36;
	localparam int SQ_PER     = 4;
	localparam int SQ_STAGES  = 8;
	localparam int DV_PER     = 4;
	localparam int DV_STAGES  = 9;
	localparam logic [33:0] STEP_MAX = 34'h2_0000_0000;

	// Stage numbers of the element pipeline
	localparam int S_WB  = 4;
	localparam int S_SQ0 = 5;
	localparam int S_DEN = S_SQ0 + SQ_STAGES;
	localparam int S_DV0 = S_DEN + 1;
	localparam int S_OUT = S_DV0 + DV_STAGES;

	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic signed [WORD_W-1:0] w;
		logic                     neg;
		logic                     sat;
	} side_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [WORD_W-1:0]   root;
	} sq_t;

	typedef struct packed {
		logic [DV_REM_W-1:0] rem;
		logic [Q_W-1:0]      q;
	} dv_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POW,
		ST_PREP,
		ST_ROOT,
		ST_MUL,
		ST_DPREP,
		ST_DIV
	} stp_state_t;

	// One digit of the integer square root, two radicand bits in
	function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] pair);
		logic [SQ_REM_W-1:0] r2;
		logic [SQ_REM_W-1:0] trial;
		sq_t                 nxt;
		r2    = {cur.rem[SQ_REM_W-3:0], pair};
		trial = {{(SQ_REM_W-WORD_W-2){1'b0}}, cur.root, 2'b01};
		if (r2 >= trial) begin
			nxt.rem  = r2 - trial;
			nxt.root = {cur.root[WORD_W-2:0], 1'b1};
		end else begin
			nxt.rem  = r2;
			nxt.root = {cur.root[WORD_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	// One quotient bit of a restoring divide
	function automatic dv_t div_step(input dv_t cur, input logic [DV_REM_W-1:0] den,
			input logic b);
		logic [DV_REM_W-1:0] r2;
		dv_t                 nxt;
		r2 = {cur.rem[DV_REM_W-2:0], b};
		if (r2 >= den) begin
			nxt.rem = r2 - den;
			nxt.q   = {cur.q[Q_W-2:0], 1'b1};
		end else begin
			nxt.rem = r2;
			nxt.q   = {cur.q[Q_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

>>> design/adam_ram.sv
`timescale 1ns / 1ps

module adam_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/adam_optimizer_update_unit.sv
`timescale 1ns / 1ps

// Adam update unit. An element word (tuser 0) carries index, weight and gradient and returns
// one updated weight word; element words stream at one per cycle while the output is not
// stalled, except that a word whose index matches one of the four words ahead of it in the
// read-modify-write part of the pipe waits until that word has written its moments back. A
// begin-step word (tuser 1) gives no output; it waits until those first four stages are empty,
// then the step unit runs a bit-serial root and a bit-serial divide for the corrected rate,
// during which no word is taken. After reset the moment RAM is swept to zero, one entry per
// cycle, and no word is taken until all 4096 entries are cleared. Registers must be written
// only while the unit is idle; the user must keep to this, as the unit does not enforce it.
module adam_optimizer_update_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// param_index[11:0], weight_in[43:12], gradient[75:44], zero fill
	input  logic [adam_pkg::IN_TDATA_W-1:0]     s_tdata,
	// opcode[0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// result_index[11:0], weight_out[43:12], saturated[44], zero fill
	output logic [adam_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                cfg_we,
	input  logic [adam_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [adam_pkg::WORD_W-1:0]         cfg_data
);

	localparam int W = adam_pkg::WORD_W;

	// Configuration registers
	logic [W-1:0] lr_q, b1_q, b2_q, eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= adam_pkg::LR_RST;
			b1_q  <= adam_pkg::B1_RST;
			b2_q  <= adam_pkg::B2_RST;
			eps_q <= adam_pkg::EPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				adam_pkg::CFG_LR:  lr_q  <= cfg_data;
				adam_pkg::CFG_B1:  b1_q  <= cfg_data;
				adam_pkg::CFG_B2:  b2_q  <= cfg_data;
				adam_pkg::CFG_EPS: eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input word fields
	logic                        in_op;
	logic [adam_pkg::IDX_W-1:0]  in_idx;
	logic signed [W-1:0]         in_w, in_g;

	assign in_op  = s_tuser;
	assign in_idx = s_tdata[11:0];
	assign in_w   = s_tdata[43:12];
	assign in_g   = s_tdata[75:44];

	// Pipeline control
	logic [adam_pkg::S_OUT:1]  vld_s;
	adam_pkg::side_t           side_s [1:adam_pkg::S_OUT];
	logic                      en, hit, busy_rmw, acc, acc_elem, acc_step;
	logic                      clear_q;
	logic [adam_pkg::IDX_W-1:0] clr_q;
	adam_pkg::stp_state_t      st_q, st_d;

	assign en       = !vld_s[adam_pkg::S_OUT] || m_tready;
	assign busy_rmw = |vld_s[adam_pkg::S_WB:1];

	// Match against words not yet written back
	always_comb begin
		hit = 1'b0;
		for (int k = 1; k <= adam_pkg::S_WB; k++) begin
			if (vld_s[k] && side_s[k].idx == in_idx) begin
				hit = 1'b1;
			end
		end
	end

	assign s_tready = en && !clear_q && st_q == adam_pkg::ST_IDLE
		&& ((in_op == adam_pkg::OP_STEP) ? !busy_rmw : !hit);
	assign acc      = s_tvalid && s_tready;
	assign acc_elem = acc && in_op == adam_pkg::OP_ELEM;
	assign acc_step = acc && in_op == adam_pkg::OP_STEP;

	// Sweep the moment RAM after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q <= 1'b1;
			clr_q   <= '0;
		end else if (clear_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == adam_pkg::IDX_W'(adam_pkg::PARAM_COUNT - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// Moment RAM: first moment low, second moment high
	logic [2*W-1:0]             mom_rd, mom_wd;
	logic [adam_pkg::IDX_W-1:0] mom_wa;
	logic                       mom_we;
	logic signed [W-1:0]        m_s4;
	logic [W-1:0]               v_s4;

	assign mom_we = clear_q || vld_s[adam_pkg::S_WB];
	assign mom_wa = clear_q ? clr_q : side_s[adam_pkg::S_WB].idx;
	assign mom_wd = clear_q ? '0 : {v_s4, m_s4};

	adam_ram #(
		.WIDTH(2 * W),
		.DEPTH(adam_pkg::PARAM_COUNT)
	) u_mom (
		.clk(clk),
		.we(mom_we),
		.waddr(mom_wa),
		.wdata(mom_wd),
		.re(en),
		.raddr(in_idx),
		.rdata(mom_rd)
	);

	// Valid bits advance with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[adam_pkg::S_OUT-1:1], acc_elem};
		end
	end

	// Side fields travel the whole pipe; sign of m and flag join at write-back
	logic signed [W-1:0] m_s3;
	logic                vsat;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= '{idx: in_idx, w: in_w, neg: 1'b0, sat: 1'b0};
			for (int k = 2; k <= adam_pkg::S_OUT; k++) begin
				side_s[k] <= side_s[k-1];
			end
			side_s[adam_pkg::S_WB].neg <= m_s3[W-1];
			side_s[adam_pkg::S_WB].sat <= vsat;
		end
	end

	// Stage 1: gradient and its magnitude
	logic signed [W-1:0] g_s1;
	logic [W-1:0]        gabs_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1    <= in_g;
			gabs_s1 <= in_g[W-1] ? W'(-in_g) : in_g;
		end
	end

	// Stage 2: moment products and gradient square
	logic signed [W-1:0]  m_old;
	logic [W-1:0]         v_old;
	logic [W:0]           a1;
	logic [2*W-1:0]       vprod, gsq_full;
	logic signed [64:0]   pm1_s2;
	logic signed [65:0]   pm2_s2;
	logic [W-1:0]         vb_s2;
	logic [47:0]          gsq_s2;

	assign m_old    = mom_rd[W-1:0];
	assign v_old    = mom_rd[2*W-1:W];
	assign a1       = adam_pkg::ONE_Q - {1'b0, b1_q};
	assign vprod    = 64'(b2_q) * 64'(v_old);
	assign gsq_full = 64'(gabs_s1) * 64'(gabs_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			pm1_s2 <= $signed({1'b0, b1_q}) * m_old;
			pm2_s2 <= $signed({1'b0, a1}) * g_s1;
			vb_s2  <= vprod[2*W-1:W];
			gsq_s2 <= gsq_full[63:16];
		end
	end

	// Stage 3: new first moment, second moment increment products
	logic signed [65:0] msum;
	logic [W:0]         a2;
	logic [64:0]        plo_full;
	logic [48:0]        phi_full;
	logic [W:0]         plo_s3;
	logic [48:0]        phi_s3;
	logic [W-1:0]       vb_s3;

	assign msum     = {pm1_s2[64], pm1_s2} + pm2_s2;
	assign a2       = adam_pkg::ONE_Q - {1'b0, b2_q};
	assign plo_full = 65'(a2) * 65'(gsq_s2[31:0]);
	assign phi_full = 49'(a2) * 49'(gsq_s2[47:32]);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3   <= msum[63:32];
			plo_s3 <= plo_full[64:32];
			phi_s3 <= phi_full;
			vb_s3  <= vb_s2;
		end
	end

	// Stage 4: second moment with saturation; written back from here
	logic [49:0] vsum;

	assign vsum = 50'(vb_s3) + 50'(phi_s3) + 50'(plo_s3);
	assign vsat = |vsum[49:W];

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4 <= m_s3;
			v_s4 <= vsat ? '1 : vsum[W-1:0];
		end
	end

	// Numerator: corrected rate times magnitude of m
	logic [W-1:0]   mabs;
	logic [2*W-1:0] num_s [adam_pkg::S_SQ0:adam_pkg::S_DEN];
	logic [W-1:0]   cr_q;

	assign mabs = m_s4[W-1] ? W'(-m_s4) : m_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[adam_pkg::S_SQ0] <= 64'(cr_q) * 64'(mabs);
			for (int k = adam_pkg::S_SQ0 + 1; k <= adam_pkg::S_DEN; k++) begin
				num_s[k] <= num_s[k-1];
			end
		end
	end

	// Root stages: four digits per stage over v with 32 zero bits below
	adam_pkg::sq_t sq_s  [adam_pkg::SQ_STAGES];
	logic [W-1:0]  sqx_s [adam_pkg::SQ_STAGES];

	for (genvar j = 0; j < adam_pkg::SQ_STAGES; j++) begin : g_sq
		adam_pkg::sq_t sq_in, sq_nx;
		logic [W-1:0]  x_in, x_nx;

		if (j == 0) begin : g_first
			assign sq_in = '0;
			assign x_in  = v_s4;
		end else begin : g_next
			assign sq_in = sq_s[j-1];
			assign x_in  = sqx_s[j-1];
		end

		always_comb begin
			sq_nx = sq_in;
			for (int i = 0; i < adam_pkg::SQ_PER; i++) begin
				sq_nx = adam_pkg::sqrt_step(sq_nx, x_in[W-1-2*i -: 2]);
			end
			x_nx = x_in << (2 * adam_pkg::SQ_PER);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[j]  <= sq_nx;
				sqx_s[j] <= x_nx;
			end
		end
	end

	// Denominator stage
	logic [adam_pkg::DV_REM_W-1:0] den_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s13 <= adam_pkg::DV_REM_W'({sq_s[adam_pkg::SQ_STAGES-1].root, 8'h00})
				+ adam_pkg::DV_REM_W'(eps_q);
		end
	end

	// Divide stages: four quotient bits per stage
	adam_pkg::dv_t                 dv_s    [adam_pkg::DV_STAGES];
	logic [adam_pkg::Q_W-1:0]      dvx_s   [adam_pkg::DV_STAGES];
	logic [adam_pkg::DV_REM_W-1:0] dden_s  [adam_pkg::DV_STAGES];
	logic                          dovf_s  [adam_pkg::DV_STAGES];
	logic                          dzero_s [adam_pkg::DV_STAGES];

	for (genvar j = 0; j < adam_pkg::DV_STAGES; j++) begin : g_dv
		adam_pkg::dv_t                 dv_in, dv_nx;
		logic [adam_pkg::Q_W-1:0]      x_in, x_nx;
		logic [adam_pkg::DV_REM_W-1:0] d_in;
		logic                          ovf_in, zero_in;

		if (j == 0) begin : g_first
			assign dv_in.rem = adam_pkg::DV_REM_W'(num_s[adam_pkg::S_DEN][2*W-1:adam_pkg::Q_W]);
			assign dv_in.q   = '0;
			assign x_in      = num_s[adam_pkg::S_DEN][adam_pkg::Q_W-1:0];
			assign d_in      = den_s13;
			assign ovf_in    = dv_in.rem >= den_s13;
			assign zero_in   = den_s13 == '0;
		end else begin : g_next
			assign dv_in   = dv_s[j-1];
			assign x_in    = dvx_s[j-1];
			assign d_in    = dden_s[j-1];
			assign ovf_in  = dovf_s[j-1];
			assign zero_in = dzero_s[j-1];
		end

		always_comb begin
			dv_nx = dv_in;
			for (int i = 0; i < adam_pkg::DV_PER; i++) begin
				dv_nx = adam_pkg::div_step(dv_nx, d_in, x_in[adam_pkg::Q_W-1-i]);
			end
			x_nx = x_in << adam_pkg::DV_PER;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j]    <= dv_nx;
				dvx_s[j]   <= x_nx;
				dden_s[j]  <= d_in;
				dovf_s[j]  <= ovf_in;
				dzero_s[j] <= zero_in;
			end
		end
	end

	// Output stage: clamp the step, apply it, saturate the weight
	localparam int LD = adam_pkg::DV_STAGES - 1;

	logic [adam_pkg::Q_W-1:0] qf;
	logic [33:0]              stepv;
	logic signed [35:0]       wx, wn;
	logic                     wsat;
	logic [W-1:0]             out_w_s23;
	logic                     out_sat_s23;

	assign qf = dv_s[LD].q;

	always_comb begin
		if (dzero_s[LD]) begin
			stepv = '0;
		end else if (dovf_s[LD] || qf > 36'(adam_pkg::STEP_MAX)) begin
			stepv = adam_pkg::STEP_MAX;
		end else begin
			stepv = qf[33:0];
		end
		wx   = 36'(side_s[adam_pkg::S_OUT-1].w);
		wn   = side_s[adam_pkg::S_OUT-1].neg ? wx + $signed(36'(stepv))
			: wx - $signed(36'(stepv));
		wsat = !(wn[35:W-1] == '0 || wn[35:W-1] == '1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_w_s23   <= wsat ? (wn[35] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
				: wn[W-1:0];
			out_sat_s23 <= side_s[adam_pkg::S_OUT-1].sat || wsat;
		end
	end

	assign m_tvalid = vld_s[adam_pkg::S_OUT];
	assign m_tdata  = {3'b000, out_sat_s23, out_w_s23, side_s[adam_pkg::S_OUT].idx};

	// Step unit: powers, root of 1 - beta2 power times the rate, divide by 1 - beta1 power
	logic [4:0]     cnt_q;
	logic [W-1:0]   step_cnt_q, b1p_q, b2p_q;
	logic [2*W-1:0] p1, p2, sx_q;
	logic [W:0]     d1_q, root33;
	logic           rfull_q, sovf_q;
	logic [64:0]    prod_q;
	adam_pkg::sq_t  ssq_q;
	adam_pkg::dv_t  sdv_q, sdv_nx;

	assign p1     = 64'(b1p_q) * 64'(b1_q);
	assign p2     = 64'(b2p_q) * 64'(b2_q);
	assign root33 = rfull_q ? adam_pkg::ONE_Q : {1'b0, ssq_q.root};
	assign sdv_nx = adam_pkg::div_step(sdv_q, adam_pkg::DV_REM_W'(d1_q), sx_q[2*W-1]);

	always_comb begin
		st_d = st_q;
		case (st_q)
			adam_pkg::ST_IDLE:  if (acc_step) st_d = adam_pkg::ST_POW;
			adam_pkg::ST_POW:   st_d = adam_pkg::ST_PREP;
			adam_pkg::ST_PREP:  st_d = adam_pkg::ST_ROOT;
			adam_pkg::ST_ROOT:  if (cnt_q == '1) st_d = adam_pkg::ST_MUL;
			adam_pkg::ST_MUL:   st_d = adam_pkg::ST_DPREP;
			adam_pkg::ST_DPREP: st_d = adam_pkg::ST_DIV;
			adam_pkg::ST_DIV:   if (cnt_q == '1) st_d = adam_pkg::ST_IDLE;
			default:            st_d = adam_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= adam_pkg::ST_IDLE;
			cnt_q      <= '0;
			step_cnt_q <= '0;
			b1p_q      <= '1;
			b2p_q      <= '1;
			cr_q       <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				adam_pkg::ST_IDLE: begin
					if (acc_step) step_cnt_q <= step_cnt_q + 1'b1;
				end
				adam_pkg::ST_POW: begin
					b1p_q <= p1[2*W-1:W];
					b2p_q <= p2[2*W-1:W];
				end
				adam_pkg::ST_PREP:  cnt_q <= '0;
				adam_pkg::ST_ROOT:  cnt_q <= cnt_q + 1'b1;
				adam_pkg::ST_DPREP: cnt_q <= '0;
				adam_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) cr_q <= sovf_q ? '1 : sdv_nx.q[W-1:0];
				end
				default: ;
			endcase
		end
	end

	// Step unit datapath
	always_ff @(posedge clk) begin
		case (st_q)
			adam_pkg::ST_PREP: begin
				d1_q    <= adam_pkg::ONE_Q - {1'b0, b1p_q};
				sx_q    <= {W'(0 - b2p_q), {W{1'b0}}};
				rfull_q <= b2p_q == '0;
				ssq_q   <= '0;
			end
			adam_pkg::ST_ROOT: begin
				ssq_q <= adam_pkg::sqrt_step(ssq_q, sx_q[2*W-1 -: 2]);
				sx_q  <= sx_q << 2;
			end
			adam_pkg::ST_MUL: begin
				prod_q <= 65'(lr_q) * 65'(root33);
			end
			adam_pkg::ST_DPREP: begin
				sdv_q.rem <= adam_pkg::DV_REM_W'(prod_q[64:W]);
				sdv_q.q   <= '0;
				sovf_q    <= prod_q[64:W] >= d1_q;
				sx_q      <= {prod_q[W-1:0], {W{1'b0}}};
			end
			adam_pkg::ST_DIV: begin
				sdv_q <= sdv_nx;
				sx_q  <= sx_q << 1;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !clear_q)
		else $error("word taken during RAM sweep");

	a_sweep_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_q |=> !clear_q)
		else $error("RAM sweep restarted");

	a_step_rmw_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != adam_pkg::ST_IDLE) |-> (vld_s[adam_pkg::S_WB:1] == '0))
		else $error("element words in moment stages while rate updates");

	a_no_rmw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[1] && vld_s[2]) |-> (side_s[1].idx != side_s[2].idx))
		else $error("same index in adjacent moment stages");
`endif

endmodule
